FILE: rtl/bgd_pkg.sv
// Shared types, codes and helpers for the button gesture detector.
// No dependencies; imported by every module of the block.
`default_nettype none
package bgd_pkg;

  localparam int BTN_W     = 3;
  localparam int MAX_BTN   = 8;
  localparam int DIV_W     = 16;
  localparam logic [31:0] RECENT_MS = 32'd500;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_FIRED = 2'd0,
    RES_DONE  = 2'd1,
    RES_ADDED = 2'd2,
    RES_FULL  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    TRG_ONCE     = 3'd0,
    TRG_MULTI    = 3'd1,
    TRG_EXACT    = 3'd2,
    TRG_HOLD     = 3'd3,
    TRG_HOLD_MOD = 3'd4
  } trig_e;

  typedef enum logic [2:0] {
    REG_TICK     = 3'd0,
    REG_HOLD_THR = 3'd1,
    REG_DEBOUNCE = 3'd2,
    REG_COOLDOWN = 3'd3,
    REG_CONT     = 3'd4,
    REG_ACTIVE   = 3'd5,
    REG_ENABLE   = 3'd6
  } reg_e;

  localparam logic [1:0] SLOT_PRESS   = 2'd0;
  localparam logic [1:0] SLOT_RELEASE = 2'd1;
  localparam logic [1:0] SLOT_END     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH_A,
    S_FETCH_B,
    S_SETUP,
    S_DIV0,
    S_DIV1,
    S_EVAL,
    S_RESP
  } walk_state_e;

  typedef struct packed {
    logic        held;
    logic [7:0]  press_cnt;
    logic [31:0] press_stamp;
    logic [7:0]  final_cnt;
    logic [31:0] final_stamp;
    logic [15:0] hold_ms;
    logic [31:0] hold_stamp;
    logic [15:0] rel_ms;
    logic [31:0] rel_stamp;
  } btn_view_t;

  typedef struct packed {
    logic [BTN_W-1:0] b1;
    logic [BTN_W-1:0] b2;
    logic             pair;
    logic [2:0]       kind;
    logic [7:0]       target;
    logic [15:0]      hold_start;
    logic [15:0]      hold_end;
    logic [15:0]      period;
    logic [2:0]       cbmask;
  } event_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic recent(input logic [31:0] now, input logic [31:0] stamp);
    logic [31:0] diff;
    diff = now - stamp;
    return diff < RECENT_MS;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bgd_button_lane.sv
// One button lane: held state, press runs, counts, hold and release times.
// Depends on bgd_pkg; one instance per button, each updated on a tick while enabled.
`default_nettype none
module bgd_button_lane
  import bgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire logic        en_i,
  input  wire logic        pressed_i,
  input  wire logic [31:0] now_i,
  input  wire logic [7:0]  tick_ms_i,
  input  wire logic [15:0] hold_thr_i,
  input  wire logic [15:0] debounce_i,
  input  wire logic [15:0] cooldown_i,
  input  wire logic [15:0] cont_i,
  output btn_view_t        view_o
);

  btn_view_t   view_q, view_d;
  logic [15:0] since_q, since_d;
  logic [7:0]  run_q, run_d;
  logic [31:0] run_stamp_q, run_stamp_d;

  always_comb begin
    view_d      = view_q;
    since_d     = since_q;
    run_d       = run_q;
    run_stamp_d = run_stamp_q;
    since_d = sat16({1'b0, since_q} + {9'b0, tick_ms_i});
    if (since_d >= cooldown_i && view_q.press_cnt != 8'd0 &&
        (now_i - view_q.press_stamp) == {16'b0, cooldown_i}) begin
      view_d.final_cnt   = view_q.press_cnt;
      view_d.final_stamp = now_i;
      since_d            = 16'd0;
    end
    if (pressed_i) begin
      if (!view_q.held) begin
        view_d.final_cnt = 8'd0;
        view_d.hold_ms   = 16'd0;
        if ((now_i - run_stamp_q) >= {16'b0, cont_i}) run_d = 8'd0;
        if (run_d != 8'hFF) run_d = run_d + 8'd1;
        run_stamp_d = now_i;
        since_d     = 16'd0;
      end
      view_d.rel_ms     = 16'd0;
      view_d.hold_ms    = sat16({1'b0, view_d.hold_ms} + {9'b0, tick_ms_i});
      view_d.hold_stamp = now_i;
      view_d.held       = 1'b1;
      if (view_d.hold_ms >= hold_thr_i) begin
        view_d.press_cnt = 8'd0;
        run_d            = 8'd0;
        view_d.final_cnt = 8'd0;
      end
    end else if (view_q.held) begin
      if (view_q.hold_ms < hold_thr_i && view_q.hold_ms >= debounce_i) begin
        view_d.press_cnt   = run_d;
        view_d.press_stamp = now_i;
        since_d            = 16'd0;
      end
      if (view_d.press_cnt == 8'd0 && view_d.press_stamp != now_i) begin
        view_d.rel_ms    = view_q.hold_ms;
        view_d.rel_stamp = now_i;
      end
      view_d.held = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q      <= '0;
      since_q     <= '0;
      run_q       <= '0;
      run_stamp_q <= '0;
    end else if (tick_i && en_i) begin
      view_q      <= view_d;
      since_q     <= since_d;
      run_q       <= run_d;
      run_stamp_q <= run_stamp_d;
    end
  end

  assign view_o = view_q;

endmodule
`default_nettype wire

FILE: rtl/bgd_rem_unit.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on bgd_pkg; reports whether the divisor is nonzero and divides.
`default_nettype none
module bgd_rem_unit
  import bgd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output logic          done_o,
  output logic          divides_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvd_q;
  logic [DIV_W-1:0] dsr_q;
  logic [CNT_W-1:0] bit_q;
  logic             run_q;
  logic             done_q;
  logic [DIV_W:0]   trial;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]} - {1'b0, dsr_q};
    if (!trial[DIV_W]) rem_d = trial[DIV_W-1:0];
    else rem_d = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        bit_q <= '0;
      end else if (run_q) begin
        bit_q <= bit_q + 1'b1;
        if (bit_q == CNT_W'(DIV_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
    end
  end

  assign done_o    = done_q;
  assign divides_o = (dsr_q != '0) && (rem_q == '0);

endmodule
`default_nettype wire

FILE: rtl/bgd_event_walker.sv
// Event table and the walk that merges the button lanes into callback beats.
// Depends on bgd_pkg and bgd_rem_unit; lane views arrive through a select mux.
`default_nettype none
module bgd_event_walker
  import bgd_pkg::*;
#(
  parameter int NUM_BUTTONS = 8,
  parameter int NUM_EVENTS  = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       operation_i,
  input  wire logic [BTN_W-1:0] first_button_i,
  input  wire logic [BTN_W-1:0] second_button_i,
  input  wire logic             is_pair_i,
  input  wire logic [2:0]       trigger_kind_i,
  input  wire logic [7:0]       press_target_i,
  input  wire logic [15:0]      hold_start_i,
  input  wire logic [15:0]      hold_end_i,
  input  wire logic [15:0]      hold_period_i,
  input  wire logic [2:0]       callback_mask_i,
  input  wire logic [7:0]       enable_i,
  input  wire logic [31:0]      now_i,
  input  wire btn_view_t        view_i,
  output logic [BTN_W-1:0]      btn_sel_o,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output logic [1:0]            kind_o,
  output logic [3:0]            event_index_o,
  output logic [1:0]            callback_slot_o,
  output logic                  last_o
);

  localparam int IDX_W = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int CNT_W = $clog2(NUM_EVENTS + 1);

  walk_state_e      state_q, state_d;
  logic             pass_q;
  logic [CNT_W-1:0] idx_q;
  logic [CNT_W-1:0] cnt_q;
  event_t           table_q [NUM_EVENTS];
  logic [2:0]       flags_q [NUM_EVENTS];
  logic [MAX_BTN-1:0] ignore_q;
  btn_view_t        snap_a_q, snap_b_q;
  logic             d0_q;
  res_kind_e        resp_kind_q;
  logic [3:0]       resp_idx_q;

  event_t           ev;
  logic [2:0]       ev_flags;
  logic [BTN_W-1:0] btn_a, btn_b;
  logic             ev_is_pair, ok_a, ok_b, ok_b1, skip;
  logic [1:0]       need_div;
  logic             accept;
  div_req_t         div_req;
  logic             div_done, div_ok;

  logic             ev_emit;
  logic [1:0]       ev_slot;
  logic             fire_en;
  logic [1:0]       fire_slot;
  logic [2:0]       set_mask, clr_mask;

  function automatic logic btn_ok(input logic [BTN_W-1:0] b, input logic [7:0] en);
    return ({1'b0, b} < (BTN_W+1)'(NUM_BUTTONS)) && en[b];
  endfunction

  assign accept   = start_i && !busy_o;
  assign ev       = table_q[idx_q[IDX_W-1:0]];
  assign ev_flags = flags_q[idx_q[IDX_W-1:0]];

  always_comb begin
    ev_is_pair = ev.pair && (ev.b1 != ev.b2);
    btn_a = (ev_is_pair && ev.b2 < ev.b1) ? ev.b2 : ev.b1;
    btn_b = (ev_is_pair && ev.b2 < ev.b1) ? ev.b1 : ev.b2;
    ok_a  = btn_ok(btn_a, enable_i);
    ok_b  = btn_ok(btn_b, enable_i);
    ok_b1 = btn_ok(ev.b1, enable_i);
    if (!pass_q) skip = !ev_is_pair || !ok_a || !ok_b;
    else skip = ev_is_pair || !ok_b1 || ignore_q[ev.b1];
    need_div = 2'd0;
    if (ev.kind == TRG_MULTI) need_div = pass_q ? 2'd1 : 2'd2;
    else if (ev.kind == TRG_HOLD_MOD) need_div = 2'd1;
  end

  assign btn_sel_o = (state_q == S_FETCH_B) ? btn_b : btn_a;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {8'b0, snap_a_q.press_cnt};
    div_req.divisor  = {8'b0, ev.target};
    if (state_q == S_SETUP) begin
      div_req.start = (need_div != 2'd0);
      if (ev.kind == TRG_HOLD_MOD) begin
        div_req.divisor = ev.period;
        if (!pass_q && !(snap_a_q.hold_stamp < snap_b_q.hold_stamp))
          div_req.dividend = snap_b_q.hold_ms;
        else
          div_req.dividend = snap_a_q.hold_ms;
      end
    end else if (state_q == S_DIV0) begin
      div_req.start    = div_done && (need_div == 2'd2);
      div_req.dividend = {8'b0, snap_b_q.press_cnt};
    end
  end

  bgd_rem_unit u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .divides_o (div_ok)
  );

  // trigger evaluation on the fetched snapshots
  always_comb begin
    logic        ok, c0, c12, c3, c4, c5, c6, c7, c1, c2, d1;
    logic [31:0] range;
    logic [31:0] st32, en32;
    btn_view_t   a, b;
    a = snap_a_q;
    b = snap_b_q;
    st32 = {16'b0, ev.hold_start};
    en32 = {16'b0, ev.hold_end};
    range = en32 - st32;
    d1 = div_ok;
    ok = 1'b0; c0 = 1'b0; c12 = 1'b0; c3 = 1'b0; c4 = 1'b0; c5 = 1'b0;
    c6 = 1'b0; c7 = 1'b0; c1 = 1'b0; c2 = 1'b0;
    ev_emit   = 1'b0;
    ev_slot   = SLOT_PRESS;
    fire_en   = 1'b0;
    fire_slot = SLOT_PRESS;
    clr_mask  = 3'b000;
    if (!pass_q) begin
      case (ev.kind)
        TRG_ONCE, TRG_MULTI: begin
          if (a.press_cnt != 8'd0 && b.press_cnt != 8'd0) begin
            if (ev.kind == TRG_ONCE)
              ok = a.press_cnt == ev.target && b.press_cnt == ev.target;
            else
              ok = d0_q && d1;
            ok = ok && recent(now_i, a.press_stamp) && recent(now_i, b.press_stamp);
            if (ok) fire_en = 1'b1;
            else clr_mask = 3'b001;
          end
        end
        TRG_EXACT: begin
          if (a.final_cnt != 8'd0 && b.final_cnt != 8'd0) begin
            ok = a.final_cnt == ev.target && b.final_cnt == ev.target &&
                 recent(now_i, a.final_stamp) && recent(now_i, b.final_stamp);
            if (ok) fire_en = 1'b1;
            else clr_mask = 3'b001;
          end
        end
        TRG_HOLD: begin
          if (a.hold_ms != 16'd0 && b.hold_ms != 16'd0) begin
            c0  = a.hold_ms >= ev.hold_start && b.hold_ms >= ev.hold_start;
            c12 = recent(now_i, a.hold_stamp) && recent(now_i, b.hold_stamp);
            c3  = a.rel_ms <= ev.hold_end && b.rel_ms <= ev.hold_end;
            c4  = ((now_i - a.rel_stamp) < range) && (a.rel_stamp != 32'd0);
            c5  = ((now_i - b.rel_stamp) < range) && (b.rel_stamp != 32'd0);
            c6  = a.hold_ms > ev.hold_end || b.hold_ms > ev.hold_end;
            c7  = a.hold_ms > ev.hold_end && b.hold_ms > ev.hold_end;
            if (c0 && c12 && !c7 && !c4 && !c5) begin
              fire_en = 1'b1;
            end else if (c0 && c3 && c4 && c5) begin
              fire_en   = 1'b1;
              fire_slot = SLOT_RELEASE;
            end else if (c6 && (c4 || c5 || c7)) begin
              fire_en   = 1'b1;
              fire_slot = SLOT_END;
            end else begin
              clr_mask = 3'b111;
            end
          end
        end
        TRG_HOLD_MOD: begin
          if (a.hold_ms != 16'd0 && b.hold_ms != 16'd0) begin
            ok = a.hold_ms >= ev.hold_start && b.hold_ms >= ev.hold_start &&
                 recent(now_i, a.hold_stamp) && recent(now_i, b.hold_stamp) &&
                 a.hold_ms <= ev.hold_end && b.hold_ms <= ev.hold_end && d0_q;
            if (ok) fire_en = 1'b1;
            else clr_mask = 3'b001;
          end
        end
        default: ;
      endcase
    end else begin
      case (ev.kind)
        TRG_ONCE:
          ev_emit = a.press_cnt != 8'd0 && a.press_cnt == ev.target &&
                    a.press_stamp == now_i && ev.cbmask[0];
        TRG_MULTI:
          ev_emit = a.press_cnt != 8'd0 && d0_q && a.press_stamp == now_i &&
                    ev.cbmask[0];
        TRG_EXACT:
          ev_emit = a.final_cnt != 8'd0 && a.final_cnt == ev.target &&
                    a.final_stamp == now_i && ev.cbmask[0];
        TRG_HOLD: begin
          c1 = a.hold_ms >= ev.hold_start;
          c0 = c1 && a.hold_stamp == now_i;
          c2 = a.rel_ms <= ev.hold_end && a.rel_stamp == now_i;
          c3 = a.hold_ms > ev.hold_end && a.hold_stamp == now_i;
          if (c0 && !c3) begin
            fire_en = 1'b1;
          end else if (c1 && c2) begin
            fire_en   = 1'b1;
            fire_slot = SLOT_RELEASE;
          end else if (c3) begin
            fire_en   = 1'b1;
            fire_slot = SLOT_END;
          end else begin
            clr_mask = 3'b111;
          end
        end
        TRG_HOLD_MOD: begin
          if (a.hold_ms != 16'd0) begin
            ok = a.hold_ms >= ev.hold_start && a.hold_ms <= ev.hold_end && d0_q &&
                 a.hold_stamp == now_i;
            if (ok) fire_en = 1'b1;
            else clr_mask = 3'b001;
          end
        end
        default: ;
      endcase
    end
    set_mask = fire_en ? (3'b001 << fire_slot) : 3'b000;
    if (fire_en) begin
      ev_emit = ev.cbmask[fire_slot] && !ev_flags[fire_slot];
      ev_slot = fire_slot;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept) state_d = (operation_i == OP_TICK) ? S_SCAN : S_RESP;
      S_SCAN: begin
        if (idx_q == cnt_q) state_d = pass_q ? S_RESP : S_SCAN;
        else if (!skip) state_d = S_FETCH_A;
      end
      S_FETCH_A: state_d = pass_q ? S_SETUP : S_FETCH_B;
      S_FETCH_B: state_d = S_SETUP;
      S_SETUP:   state_d = (need_div != 2'd0) ? S_DIV0 : S_EVAL;
      S_DIV0:    if (div_done) state_d = (need_div == 2'd2) ? S_DIV1 : S_EVAL;
      S_DIV1:    if (div_done) state_d = S_EVAL;
      S_EVAL:    state_d = S_SCAN;
      S_RESP:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o          = (state_q != S_IDLE);
    result_valid_o  = 1'b0;
    kind_o          = RES_FIRED;
    event_index_o   = 4'(idx_q);
    callback_slot_o = SLOT_PRESS;
    last_o          = 1'b0;
    case (state_q)
      S_EVAL: begin
        result_valid_o  = ev_emit;
        callback_slot_o = ev_slot;
      end
      S_RESP: begin
        result_valid_o = 1'b1;
        kind_o         = resp_kind_q;
        event_index_o  = resp_idx_q;
        last_o         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      ignore_q    <= '0;
      resp_kind_q <= RES_DONE;
      resp_idx_q  <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) flags_q[i] <= 3'b000;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pass_q      <= 1'b0;
            idx_q       <= '0;
            ignore_q    <= '0;
            resp_kind_q <= RES_DONE;
            resp_idx_q  <= '0;
            if (operation_i == OP_ADD) begin
              if (cnt_q >= CNT_W'(NUM_EVENTS)) begin
                resp_kind_q <= RES_FULL;
              end else begin
                resp_kind_q <= RES_ADDED;
                resp_idx_q  <= 4'(cnt_q);
                flags_q[cnt_q[IDX_W-1:0]] <= 3'b000;
                cnt_q       <= cnt_q + 1'b1;
              end
            end else if (operation_i == OP_CLEAR) begin
              cnt_q <= '0;
            end
          end
        end
        S_SCAN: begin
          if (idx_q == cnt_q) begin
            if (!pass_q) begin
              pass_q <= 1'b1;
              idx_q  <= '0;
            end
          end else if (skip) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_EVAL: begin
          flags_q[idx_q[IDX_W-1:0]] <= (ev_flags | set_mask) & ~clr_mask;
          if (!pass_q && snap_a_q.held && snap_b_q.held) begin
            ignore_q[btn_a] <= 1'b1;
            ignore_q[btn_b] <= 1'b1;
          end
          idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && operation_i == OP_ADD &&
        cnt_q < CNT_W'(NUM_EVENTS)) begin
      table_q[cnt_q[IDX_W-1:0]] <= '{b1: first_button_i, b2: second_button_i,
                                     pair: is_pair_i, kind: trigger_kind_i,
                                     target: press_target_i,
                                     hold_start: hold_start_i,
                                     hold_end: hold_end_i, period: hold_period_i,
                                     cbmask: callback_mask_i};
    end
    if (state_q == S_FETCH_A) snap_a_q <= view_i;
    if (state_q == S_FETCH_B) snap_b_q <= view_i;
    if (state_q == S_DIV0 && div_done) d0_q <= div_ok;
  end

`ifndef ASSERT_OFF
  a_beat_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result beat while idle");
  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !busy_o)
    else $error("still busy after last beat");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_EVENTS))
    else $error("event count overflow");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted item not started");
`endif

endmodule
`default_nettype wire

FILE: rtl/button_gesture_detector_top.sv
// Top level: APB register file, millisecond timer, button lanes, event walker.
// Depends on bgd_pkg, bgd_button_lane, bgd_event_walker.
//
// Usage: an item is taken when start_i is high and busy_o is low.
// operation_i selects tick, add event, clear table or none. Results come out as
// single-cycle beats marked by result_valid_o; the receiver cannot stall them,
// and the final beat of an item carries last_o.
// A tick updates every enabled button lane in parallel in the accept cycle,
// then walks the event table twice (pair events, then single events). Each
// visited event goes through scan, fetch of one or both lane snapshots, setup,
// remainder waits where needed and evaluation. Remainders are computed by the
// shared bit-serial remainder unit (one for multi-press singles and hold
// modulo, two for multi-press pairs). Skipped events only advance the scan
// index. Add, clear and no-operation items give one beat from the response
// state. Reset clears the timer, all lanes, the event count and done flags,
// and loads the register defaults. Registers must be written only while
// busy_o is low; the block itself does not enforce it.
`default_nettype none
module button_gesture_detector_top
  import bgd_pkg::*;
#(
  parameter int NUM_BUTTONS = 8,
  parameter int NUM_EVENTS  = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [7:0]       levels_i,
  input  wire logic [2:0]       first_button_i,
  input  wire logic [2:0]       second_button_i,
  input  wire logic             is_pair_i,
  input  wire logic [2:0]       trigger_kind_i,
  input  wire logic [7:0]       press_target_i,
  input  wire logic [15:0]      hold_start_i,
  input  wire logic [15:0]      hold_end_i,
  input  wire logic [15:0]      hold_period_i,
  input  wire logic [2:0]       callback_mask_i,
  output logic                  result_valid_o,
  output logic [1:0]            kind_o,
  output logic [3:0]            event_index_o,
  output logic [1:0]            callback_slot_o,
  output logic                  last_o
);

  logic [7:0]  tick_ms_q;
  logic [15:0] hold_thr_q, debounce_q, cooldown_q, cont_q;
  logic [7:0]  active_q, enable_q;
  logic [31:0] now_q, now_d;
  logic        wr_en, tick_go;
  logic [2:0]  reg_idx;
  btn_view_t   views [MAX_BTN];
  btn_view_t   sel_view;
  logic [BTN_W-1:0] btn_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q  <= 8'd10;
      hold_thr_q <= 16'd1000;
      debounce_q <= 16'd30;
      cooldown_q <= 16'd400;
      cont_q     <= 16'd400;
      active_q   <= 8'd0;
      enable_q   <= 8'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK:     tick_ms_q  <= pwdata[7:0];
        REG_HOLD_THR: hold_thr_q <= pwdata[15:0];
        REG_DEBOUNCE: debounce_q <= pwdata[15:0];
        REG_COOLDOWN: cooldown_q <= pwdata[15:0];
        REG_CONT:     cont_q     <= pwdata[15:0];
        REG_ACTIVE:   active_q   <= pwdata[7:0];
        REG_ENABLE:   enable_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK:     prdata = {24'b0, tick_ms_q};
      REG_HOLD_THR: prdata = {16'b0, hold_thr_q};
      REG_DEBOUNCE: prdata = {16'b0, debounce_q};
      REG_COOLDOWN: prdata = {16'b0, cooldown_q};
      REG_CONT:     prdata = {16'b0, cont_q};
      REG_ACTIVE:   prdata = {24'b0, active_q};
      REG_ENABLE:   prdata = {24'b0, enable_q};
      default:      prdata = 32'd0;
    endcase
  end

  assign tick_go = start_i && !busy_o && (operation_i == OP_TICK);
  assign now_d   = now_q + {24'b0, tick_ms_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) now_q <= '0;
    else if (tick_go) now_q <= now_d;
  end

  for (genvar g = 0; g < MAX_BTN; g++) begin : g_lane
    if (g < NUM_BUTTONS) begin : g_on
      bgd_button_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tick_i     (tick_go),
        .en_i       (enable_q[g]),
        .pressed_i  (levels_i[g] == active_q[g]),
        .now_i      (now_d),
        .tick_ms_i  (tick_ms_q),
        .hold_thr_i (hold_thr_q),
        .debounce_i (debounce_q),
        .cooldown_i (cooldown_q),
        .cont_i     (cont_q),
        .view_o     (views[g])
      );
    end else begin : g_off
      assign views[g] = '0;
    end
  end

  assign sel_view = views[btn_sel];

  bgd_event_walker #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_EVENTS  (NUM_EVENTS)
  ) u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .operation_i     (operation_i),
    .first_button_i  (first_button_i),
    .second_button_i (second_button_i),
    .is_pair_i       (is_pair_i),
    .trigger_kind_i  (trigger_kind_i),
    .press_target_i  (press_target_i),
    .hold_start_i    (hold_start_i),
    .hold_end_i      (hold_end_i),
    .hold_period_i   (hold_period_i),
    .callback_mask_i (callback_mask_i),
    .enable_i        (enable_q),
    .now_i           (now_q),
    .view_i          (sel_view),
    .btn_sel_o       (btn_sel),
    .busy_o          (busy_o),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .event_index_o   (event_index_o),
    .callback_slot_o (callback_slot_o),
    .last_o          (last_o)
  );

endmodule
`default_nettype wire

FILE: bench/gesture_checker.sv
// Checker for the button gesture detector: watches the register port, the item
// channel and the result beats, predicts each item's beats and compares them.
// Depends on bgd_pkg for item, result and register codes.
`timescale 1ns / 100ps
module gesture_checker
  import bgd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  levels_i,
  input  wire logic [2:0]  first_button_i,
  input  wire logic [2:0]  second_button_i,
  input  wire logic        is_pair_i,
  input  wire logic [2:0]  trigger_kind_i,
  input  wire logic [7:0]  press_target_i,
  input  wire logic [15:0] hold_start_i,
  input  wire logic [15:0] hold_end_i,
  input  wire logic [15:0] hold_period_i,
  input  wire logic [2:0]  callback_mask_i,
  input  wire logic        result_valid_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [3:0]  event_index_i,
  input  wire logic [1:0]  callback_slot_i,
  input  wire logic        last_i,
  output int               errors_o,
  output int               pending_o,
  output int               beats_o
);

  typedef struct {
    res_kind_e  kind;
    logic [3:0] idx;
    logic [1:0] slot;
    logic       last;
  } beat_t;

  beat_t expected_beats[$];

  logic [7:0]  cfg_tick;
  logic [15:0] cfg_hold_thr, cfg_debounce, cfg_cooldown, cfg_cont;
  logic [7:0]  cfg_active, cfg_enable;

  logic [31:0] now_ms;
  logic        held[8];
  logic [15:0] since_chg[8];
  logic [7:0]  run_cnt[8];
  logic [31:0] run_stamp[8];
  logic [7:0]  press_cnt[8];
  logic [31:0] press_stamp[8];
  logic [7:0]  final_cnt[8];
  logic [31:0] final_stamp[8];
  logic [15:0] hold_ms[8];
  logic [31:0] hold_stamp[8];
  logic [15:0] rel_ms[8];
  logic [31:0] rel_stamp[8];
  event_t      gestures[16];
  logic [2:0]  handled[16];
  int          gesture_cnt;

  assign pending_o = expected_beats.size();

  task automatic report(input string what, input int got, input int want);
    errors_o++;
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic push_beat(input res_kind_e k, input int i, input int s, input logic l);
    beat_t b;
    b.kind = k; b.idx = i[3:0]; b.slot = s[1:0]; b.last = l;
    expected_beats.push_back(b);
  endtask

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic divisible(input logic [31:0] x, input logic [31:0] d);
    return d != 0 && (x % d) == 0;
  endfunction

  function automatic logic fresh(input logic [31:0] stamp);
    return (now_ms - stamp) < 32'd500;
  endfunction

  function automatic logic usable(input logic [2:0] b);
    return cfg_enable[b];
  endfunction

  task automatic mark(input int i, input int s);
    if (gestures[i].cbmask[s] && !handled[i][s]) push_beat(RES_FIRED, i, s, 1'b0);
    handled[i][s] = 1'b1;
  endtask

  task automatic unmark(input int i, input logic [2:0] bits);
    handled[i] = handled[i] & ~bits;
  endtask

  task automatic step_button(input int i, input logic [7:0] lv);
    logic [31:0] t;
    t = now_ms;
    since_chg[i] = clip16({16'd0, since_chg[i]} + {24'd0, cfg_tick});
    if (since_chg[i] >= cfg_cooldown && press_cnt[i] > 0 &&
        (t - press_stamp[i]) == {16'd0, cfg_cooldown}) begin
      final_cnt[i] = press_cnt[i];
      final_stamp[i] = t;
      since_chg[i] = 0;
    end
    if (lv[i] == cfg_active[i]) begin
      if (!held[i]) begin
        final_cnt[i] = 0;
        hold_ms[i] = 0;
        if ((t - run_stamp[i]) >= {16'd0, cfg_cont}) run_cnt[i] = 0;
        if (run_cnt[i] < 8'd255) run_cnt[i]++;
        run_stamp[i] = t;
        since_chg[i] = 0;
      end
      rel_ms[i] = 0;
      hold_ms[i] = clip16({16'd0, hold_ms[i]} + {24'd0, cfg_tick});
      hold_stamp[i] = t;
      held[i] = 1'b1;
      if (hold_ms[i] >= cfg_hold_thr) begin
        press_cnt[i] = 0;
        run_cnt[i] = 0;
        final_cnt[i] = 0;
      end
    end else if (held[i]) begin
      if (hold_ms[i] < cfg_hold_thr && hold_ms[i] >= cfg_debounce) begin
        press_cnt[i] = run_cnt[i];
        press_stamp[i] = t;
        since_chg[i] = 0;
      end
      if (press_cnt[i] == 0 && press_stamp[i] != t) begin
        rel_ms[i] = hold_ms[i];
        rel_stamp[i] = t;
      end
      held[i] = 1'b0;
    end
  endtask

  task automatic check_pair(input int i, input int a, input int b);
    event_t e;
    logic [31:0] tg, st, en, rng;
    logic ok, c0, c12, c3, c4, c5, c6, c7;
    e = gestures[i];
    tg = {24'd0, e.target}; st = {16'd0, e.hold_start}; en = {16'd0, e.hold_end};
    case (e.kind)
      TRG_ONCE, TRG_MULTI: begin
        if (press_cnt[a] == 0 || press_cnt[b] == 0) return;
        if (e.kind == TRG_ONCE) ok = press_cnt[a] == tg && press_cnt[b] == tg;
        else ok = divisible(press_cnt[a], tg) && divisible(press_cnt[b], tg);
        ok = ok && fresh(press_stamp[a]) && fresh(press_stamp[b]);
        if (ok) mark(i, SLOT_PRESS); else unmark(i, 3'b001);
      end
      TRG_EXACT: begin
        if (final_cnt[a] == 0 || final_cnt[b] == 0) return;
        ok = final_cnt[a] == tg && final_cnt[b] == tg &&
             fresh(final_stamp[a]) && fresh(final_stamp[b]);
        if (ok) mark(i, SLOT_PRESS); else unmark(i, 3'b001);
      end
      TRG_HOLD: begin
        if (hold_ms[a] == 0 || hold_ms[b] == 0) return;
        rng = en - st;
        c0 = hold_ms[a] >= st && hold_ms[b] >= st;
        c12 = fresh(hold_stamp[a]) && fresh(hold_stamp[b]);
        c3 = rel_ms[a] <= en && rel_ms[b] <= en;
        c4 = (now_ms - rel_stamp[a]) < rng && rel_stamp[a] != 0;
        c5 = (now_ms - rel_stamp[b]) < rng && rel_stamp[b] != 0;
        c6 = hold_ms[a] > en || hold_ms[b] > en;
        c7 = hold_ms[a] > en && hold_ms[b] > en;
        if (c0 && c12 && !c7 && !c4 && !c5) mark(i, SLOT_PRESS);
        else if (c0 && c3 && c4 && c5) mark(i, SLOT_RELEASE);
        else if (c6 && (c4 || c5 || c7)) mark(i, SLOT_END);
        else unmark(i, 3'b111);
      end
      TRG_HOLD_MOD: begin
        if (hold_ms[a] == 0 || hold_ms[b] == 0) return;
        if (hold_stamp[a] < hold_stamp[b]) c4 = divisible(hold_ms[a], e.period);
        else c4 = divisible(hold_ms[b], e.period);
        ok = hold_ms[a] >= st && hold_ms[b] >= st &&
             fresh(hold_stamp[a]) && fresh(hold_stamp[b]) &&
             hold_ms[a] <= en && hold_ms[b] <= en && c4;
        if (ok) mark(i, SLOT_PRESS); else unmark(i, 3'b001);
      end
      default: ;
    endcase
  endtask

  task automatic check_single(input int i, input int b);
    event_t e;
    logic [31:0] tg, st, en, t;
    logic c0, c1, c2, c3;
    e = gestures[i];
    tg = {24'd0, e.target}; st = {16'd0, e.hold_start}; en = {16'd0, e.hold_end};
    t = now_ms;
    case (e.kind)
      TRG_ONCE: begin
        if (press_cnt[b] == 0) return;
        if (press_cnt[b] == tg && press_stamp[b] == t && e.cbmask[0])
          push_beat(RES_FIRED, i, SLOT_PRESS, 1'b0);
      end
      TRG_MULTI: begin
        if (press_cnt[b] == 0) return;
        if (divisible(press_cnt[b], tg) && press_stamp[b] == t && e.cbmask[0])
          push_beat(RES_FIRED, i, SLOT_PRESS, 1'b0);
      end
      TRG_EXACT: begin
        if (final_cnt[b] == 0) return;
        if (final_cnt[b] == tg && final_stamp[b] == t && e.cbmask[0])
          push_beat(RES_FIRED, i, SLOT_PRESS, 1'b0);
      end
      TRG_HOLD: begin
        c1 = hold_ms[b] >= st;
        c0 = c1 && hold_stamp[b] == t;
        c2 = rel_ms[b] <= en && rel_stamp[b] == t;
        c3 = hold_ms[b] > en && hold_stamp[b] == t;
        if (c0 && !c3) mark(i, SLOT_PRESS);
        else if (c1 && c2) mark(i, SLOT_RELEASE);
        else if (c3) mark(i, SLOT_END);
        else unmark(i, 3'b111);
      end
      TRG_HOLD_MOD: begin
        if (hold_ms[b] == 0) return;
        if (hold_ms[b] >= st && hold_ms[b] <= en &&
            divisible(hold_ms[b], e.period) && hold_stamp[b] == t)
          mark(i, SLOT_PRESS);
        else
          unmark(i, 3'b001);
      end
      default: ;
    endcase
  endtask

  task automatic predict_tick(input logic [7:0] lv);
    logic [7:0] skip;
    int a, b;
    skip = '0;
    now_ms = now_ms + {24'd0, cfg_tick};
    for (int i = 0; i < 8; i++)
      if (usable(i[2:0])) step_button(i, lv);
    for (int i = 0; i < gesture_cnt; i++) begin
      if (!(gestures[i].pair && gestures[i].b1 != gestures[i].b2)) continue;
      a = (gestures[i].b1 < gestures[i].b2) ? gestures[i].b1 : gestures[i].b2;
      b = (gestures[i].b1 < gestures[i].b2) ? gestures[i].b2 : gestures[i].b1;
      if (!usable(a[2:0]) || !usable(b[2:0])) continue;
      if (held[a] && held[b]) begin
        skip[a] = 1'b1;
        skip[b] = 1'b1;
      end
      check_pair(i, a, b);
    end
    for (int i = 0; i < gesture_cnt; i++) begin
      if (gestures[i].pair && gestures[i].b1 != gestures[i].b2) continue;
      if (!usable(gestures[i].b1) || skip[gestures[i].b1]) continue;
      check_single(i, gestures[i].b1);
    end
    push_beat(RES_DONE, 0, 0, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t w;
    if (!rst_ni) begin
      cfg_tick <= 8'd10; cfg_hold_thr <= 16'd1000; cfg_debounce <= 16'd30;
      cfg_cooldown <= 16'd400; cfg_cont <= 16'd400;
      cfg_active <= '0; cfg_enable <= '0;
      now_ms <= '0;
      for (int i = 0; i < 8; i++) begin
        held[i] <= 0; since_chg[i] <= 0; run_cnt[i] <= 0; run_stamp[i] <= 0;
        press_cnt[i] <= 0; press_stamp[i] <= 0; final_cnt[i] <= 0;
        final_stamp[i] <= 0; hold_ms[i] <= 0; hold_stamp[i] <= 0;
        rel_ms[i] <= 0; rel_stamp[i] <= 0;
      end
      for (int i = 0; i < 16; i++) handled[i] <= '0;
      gesture_cnt <= 0;
      errors_o <= 0;
      beats_o <= 0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TICK:     cfg_tick = pwdata[7:0];
          REG_HOLD_THR: cfg_hold_thr = pwdata[15:0];
          REG_DEBOUNCE: cfg_debounce = pwdata[15:0];
          REG_COOLDOWN: cfg_cooldown = pwdata[15:0];
          REG_CONT:     cfg_cont = pwdata[15:0];
          REG_ACTIVE:   cfg_active = pwdata[7:0];
          REG_ENABLE:   cfg_enable = pwdata[7:0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        beats_o = beats_o + 1;
        if (expected_beats.size() == 0) begin
          report("unexpected beat kind", kind_i, -1);
        end else begin
          w = expected_beats.pop_front();
          if (kind_i != w.kind) report("kind", kind_i, w.kind);
          if (event_index_i != w.idx) report("event_index", event_index_i, w.idx);
          if (callback_slot_i != w.slot) report("callback_slot", callback_slot_i, w.slot);
          if (last_i != w.last) report("last", last_i, w.last);
        end
      end
      if (start_i && !busy_i) begin
        case (op_e'(operation_i))
          OP_TICK: predict_tick(levels_i);
          OP_ADD: begin
            if (gesture_cnt >= 16) begin
              push_beat(RES_FULL, 0, 0, 1'b1);
            end else begin
              gestures[gesture_cnt].b1 = first_button_i;
              gestures[gesture_cnt].b2 = second_button_i;
              gestures[gesture_cnt].pair = is_pair_i;
              gestures[gesture_cnt].kind = trigger_kind_i;
              gestures[gesture_cnt].target = press_target_i;
              gestures[gesture_cnt].hold_start = hold_start_i;
              gestures[gesture_cnt].hold_end = hold_end_i;
              gestures[gesture_cnt].period = hold_period_i;
              gestures[gesture_cnt].cbmask = callback_mask_i;
              handled[gesture_cnt] = '0;
              push_beat(RES_ADDED, gesture_cnt, 0, 1'b1);
              gesture_cnt = gesture_cnt + 1;
            end
          end
          OP_CLEAR: begin
            gesture_cnt = 0;
            push_beat(RES_DONE, 0, 0, 1'b1);
          end
          default: push_beat(RES_DONE, 0, 0, 1'b1);
        endcase
      end
    end
  end

endmodule

FILE: bench/tb.sv
// Testbench top for the button gesture detector: clock, reset, register writes,
// directed and random items with sender gaps; verdict from gesture_checker.
// Depends on bgd_pkg, button_gesture_detector_top and gesture_checker.
`timescale 1ns / 100ps
module tb;
  import bgd_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0, rst_n = 1'b0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready, busy, res_valid, res_last, start = 0;
  logic [1:0] operation = OP_TICK;
  logic [7:0] levels = '0, target = 8'd1;
  logic [2:0] first_btn = '0, second_btn = '0, trig = TRG_ONCE, cbmask = '0;
  logic pair = 0;
  logic [15:0] hold_start = '0, hold_end = '0, period = 16'd1;
  logic [1:0] res_kind, res_slot;
  logic [3:0] res_idx;
  int errors, pending, beats, items, idle_cycles, gap_pct;
  logic [7:0] act_bits, en_bits, tick_ms;
  logic pressed[8];
  int hold_left[8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_gesture_detector_top dut (
    .clk_i(clk), .rst_ni(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start_i(start), .busy_o(busy), .operation_i(operation), .levels_i(levels),
    .first_button_i(first_btn), .second_button_i(second_btn), .is_pair_i(pair),
    .trigger_kind_i(trig), .press_target_i(target), .hold_start_i(hold_start),
    .hold_end_i(hold_end), .hold_period_i(period), .callback_mask_i(cbmask),
    .result_valid_o(res_valid), .kind_o(res_kind), .event_index_o(res_idx),
    .callback_slot_o(res_slot), .last_o(res_last)
  );

  gesture_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready), .start_i(start), .busy_i(busy),
    .operation_i(operation), .levels_i(levels), .first_button_i(first_btn),
    .second_button_i(second_btn), .is_pair_i(pair), .trigger_kind_i(trig),
    .press_target_i(target), .hold_start_i(hold_start), .hold_end_i(hold_end),
    .hold_period_i(period), .callback_mask_i(cbmask), .result_valid_i(res_valid),
    .kind_i(res_kind), .event_index_i(res_idx), .callback_slot_i(res_slot),
    .last_i(res_last), .errors_o(errors), .pending_o(pending), .beats_o(beats)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge; start stays high after the item is taken unless a random gap drops it
  task automatic issue(input op_e op);
    operation <= op;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(negedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input logic [7:0] tk, input logic [15:0] thr, input logic [15:0] deb,
                       input logic [15:0] cool, input logic [15:0] cont,
                       input logic [7:0] act, input logic [7:0] en);
    drain();
    write_reg(REG_TICK, tk);
    write_reg(REG_HOLD_THR, thr);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_CONT, cont);
    write_reg(REG_ACTIVE, act);
    write_reg(REG_ENABLE, en);
    tick_ms = tk; act_bits = act; en_bits = en;
  endtask

  task automatic add_gesture(input logic [2:0] b1, input logic [2:0] b2, input logic pr,
                             input trig_e k, input logic [7:0] tg, input logic [15:0] st,
                             input logic [15:0] en, input logic [15:0] per,
                             input logic [2:0] cm);
    first_btn <= b1; second_btn <= b2; pair <= pr; trig <= k; target <= tg;
    hold_start <= st; hold_end <= en; period <= per; cbmask <= cm;
    issue(OP_ADD);
  endtask

  task automatic add_random_gesture();
    logic [2:0] k;
    logic [31:0] st;
    k = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    st = tick_ms * $urandom_range(0, 8);
    first_btn <= $urandom_range(0, 7);
    second_btn <= $urandom_range(0, 7);
    pair <= $urandom_range(0, 9) < 4;
    trig <= k;
    target <= ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
    if ($urandom_range(9) == 0) begin
      hold_start <= $urandom; hold_end <= $urandom; period <= $urandom;
    end else begin
      hold_start <= st[15:0];
      hold_end <= 16'(st + tick_ms * $urandom_range(0, 12));
      period <= 16'(tick_ms * $urandom_range(1, 4));
    end
    cbmask <= $urandom_range(0, 7);
    issue(OP_ADD);
  endtask

  task automatic tick_levels(input logic [7:0] lv);
    levels <= lv;
    issue(OP_TICK);
  endtask

  task automatic random_phase(input int n, input int sh_lo, input int sh_hi,
                              input int lg_lo, input int lg_hi, input int gap_hi);
    logic [7:0] lv;
    drain();
    issue(OP_CLEAR);
    repeat ($urandom_range(4, 17)) add_random_gesture();
    for (int b = 0; b < 8; b++) begin
      pressed[b] = 0;
      hold_left[b] = 0;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      if ($urandom_range(49) == 0) begin
        if ($urandom_range(1)) add_random_gesture(); else issue(OP_NONE);
        continue;
      end
      for (int b = 0; b < 8; b++) begin
        if (hold_left[b] == 0) begin
          pressed[b] = !pressed[b];
          if (!pressed[b]) hold_left[b] = $urandom_range(1, gap_hi);
          else if ($urandom_range(9) < 7) hold_left[b] = $urandom_range(sh_lo, sh_hi);
          else hold_left[b] = $urandom_range(lg_lo, lg_hi);
        end
        hold_left[b]--;
        lv[b] = pressed[b] ? act_bits[b] : ~act_bits[b];
      end
      if ($urandom_range(19) == 0) lv = $urandom;
      tick_levels(lv);
    end
  endtask

  initial begin
    items = 0;
    gap_pct = 22;
    tick_ms = 8'd10; act_bits = '0; en_bits = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one of each trigger, pair on one button, disabled button,
    // unknown trigger, zero divisors, field extremes, full table, clear
    write_reg(REG_ENABLE, 8'hF3);
    en_bits = 8'hF3;
    add_gesture(3'd0, 3'd0, 1'b0, TRG_ONCE, 8'd1, 16'd0, 16'hFFFF, 16'd1, 3'b111);
    add_gesture(3'd0, 3'd1, 1'b1, TRG_ONCE, 8'd1, 16'd0, 16'd0, 16'd1, 3'b001);
    add_gesture(3'd4, 3'd4, 1'b1, TRG_HOLD, 8'd255, 16'd20, 16'd60, 16'hFFFF, 3'b111);
    add_gesture(3'd2, 3'd7, 1'b0, TRG_MULTI, 8'd0, 16'd0, 16'd0, 16'd0, 3'b111);
    add_gesture(3'd1, 3'd5, 1'b0, trig_e'(3'd7), 8'd1, 16'd0, 16'd100, 16'd1, 3'b111);
    add_gesture(3'd7, 3'd6, 1'b1, TRG_HOLD_MOD, 8'd1, 16'd10, 16'd500, 16'd0, 3'b111);
    add_gesture(3'd5, 3'd0, 1'b0, TRG_EXACT, 8'd2, 16'd0, 16'd0, 16'd20, 3'b110);
    add_gesture(3'd6, 3'd2, 1'b0, TRG_HOLD_MOD, 8'd1, 16'd10, 16'd300, 16'd20, 3'b111);
    tick_levels(8'hFF);
    tick_levels(8'hFF);
    tick_levels(8'hFF);
    tick_levels(8'hFF);
    tick_levels(8'h00);
    tick_levels(8'hFF);
    tick_levels(8'hFF);
    tick_levels(8'hFF);
    tick_levels(8'h00);
    repeat (9) add_random_gesture();
    issue(OP_NONE);
    issue(OP_CLEAR);

    setup(8'd10, 16'd120, 16'd20, 16'd60, 16'd60, 8'hA5, 8'hFF);
    random_phase(140, 2, 11, 12, 40, 8);
    gap_pct = 63;
    setup(8'd255, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'h00, 8'h7F);
    random_phase(140, 1, 5, 1, 5, 4);
    gap_pct = 0;
    setup(8'd1, 16'd5, 16'd2, 16'd8, 16'd6, 8'h5A, 8'hFF);
    random_phase(140, 2, 4, 5, 12, 10);

    drain();
    repeat (50) @(posedge clk);
    $display("run covered %0d items across directed and three register settings", items);
    $display("%0d result beats compared, %0d mismatches", beats, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bgd_pkg.sv
rtl/bgd_button_lane.sv
rtl/bgd_rem_unit.sv
rtl/bgd_event_walker.sv
rtl/button_gesture_detector_top.sv
bench/gesture_checker.sv
bench/tb.sv
